// ===== hdl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Beat types, substitution tables, round constants and the round and key
// schedule functions shared by the cipher pipeline stages.
// ----------------------------------------------------------------------------
package aes_pkg;

  typedef struct packed {
    logic        action;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_beat_t;

  // data carried from stage to stage
  typedef struct packed {
    logic         action;
    logic [127:0] key;
    logic [127:0] rk;
    logic [127:0] blk;
  } stg_t;

  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;
  localparam int   NUM_ROUNDS  = 10;

  localparam logic [7:0] RCON [10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    t = '0;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
    end
    return t;
  endfunction

  // byte r + 4c sits at bits 127-8(r+4c)
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int o;
    int p;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o = r + 4 * ((c + r) % 4);
        p = r + 4 * c;
        if (inv) begin
          t[127-8*o -: 8] = s[127-8*p -: 8];
        end else begin
          t[127-8*p -: 8] = s[127-8*o -: 8];
        end
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] a2 [4];
    logic [7:0] a4 [4];
    logic [7:0] a8 [4];
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m0 [4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j]  = s[127-8*(4*c+j) -: 8];
        a2[j] = xt(a[j]);
        a4[j] = xt(a2[j]);
        a8[j] = xt(a4[j]);
        if (inv) begin
          m0[j] = a8[j] ^ a4[j] ^ a2[j];
          m1[j] = a8[j] ^ a2[j] ^ a[j];
          m2[j] = a8[j] ^ a4[j] ^ a[j];
          m3[j] = a8[j] ^ a[j];
        end else begin
          m0[j] = a2[j];
          m1[j] = a2[j] ^ a[j];
          m2[j] = a[j];
          m3[j] = a[j];
        end
      end
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = m0[r] ^ m1[(r+1)%4] ^ m2[(r+2)%4] ^ m3[(r+3)%4];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
    return {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[127:96] ^ sub_rot(k[31:0], rc);
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] p0, p1, p2, p3;
    p3 = k[31:0] ^ k[63:32];
    p2 = k[63:32] ^ k[95:64];
    p1 = k[95:64] ^ k[127:96];
    p0 = k[127:96] ^ sub_rot(p3, rc);
    return {p0, p1, p2, p3};
  endfunction

endpackage

// ===== hdl/aes_key_stage.sv =====
// ----------------------------------------------------------------------------
// aes_key_stage
// One forward key schedule step with its pipeline register, run ahead of the
// rounds so that decryption has the last round key at hand.
// ----------------------------------------------------------------------------
module aes_key_stage
  import aes_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  stg_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output stg_t out_data
);

  localparam logic [3:0] RC_IDX = 4'(STEP);

  logic valid_r;
  stg_t data_r;
  stg_t data_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    data_nxt    = in_data;
    data_nxt.rk = key_fwd(in_data.rk, RCON[RC_IDX]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== hdl/aes_round_stage.sv =====
// ----------------------------------------------------------------------------
// aes_round_stage
// One cipher round, encrypt or decrypt per beat, with the matching round key
// step (forward for encrypt, backward for decrypt) and its pipeline register.
// ----------------------------------------------------------------------------
module aes_round_stage
  import aes_pkg::*;
#(
  parameter int ROUND = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  stg_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output stg_t out_data
);

  localparam logic [3:0] ENC_IDX = 4'((ROUND < NUM_ROUNDS) ? ROUND : 0);
  localparam logic [3:0] DEC_IDX = 4'((ROUND < NUM_ROUNDS) ? NUM_ROUNDS - 1 - ROUND : 0);
  localparam bit HAS_SUB = (ROUND > 0);
  localparam bit HAS_MIX = (ROUND > 0) && (ROUND < NUM_ROUNDS);

  logic         valid_r;
  stg_t         data_r;
  stg_t         data_nxt;
  logic [127:0] enc_s;
  logic [127:0] dec_s;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    enc_s = in_data.blk;
    dec_s = in_data.blk;
    if (HAS_SUB) begin
      enc_s = shift_rows(sub_bytes(in_data.blk, 1'b0), 1'b0);
      dec_s = sub_bytes(shift_rows(in_data.blk, 1'b1), 1'b1);
    end
    if (HAS_MIX) begin
      enc_s = mix_cols(enc_s, 1'b0);
    end
    enc_s = enc_s ^ in_data.rk;
    dec_s = dec_s ^ in_data.rk;
    if (HAS_MIX) begin
      dec_s = mix_cols(dec_s, 1'b1);
    end
    data_nxt = in_data;
    if (in_data.action == ACT_DECRYPT) begin
      data_nxt.blk = dec_s;
      data_nxt.rk  = key_inv(in_data.rk, RCON[DEC_IDX]);
    end else begin
      data_nxt.blk = enc_s;
      data_nxt.rk  = key_fwd(in_data.rk, RCON[ENC_IDX]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== hdl/aes128_block_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// aes128_block_cipher_unit
// AES-128 single block cipher, encrypt or decrypt chosen per beat, with the
// key expanded afresh for every beat.
//
// in_data carries action, key and block; out_data carries the result. Both
// channels are valid/ready. The pipeline has 21 register stages: ten key
// schedule steps that bring the last round key forward, then the initial
// key addition and ten rounds, each beat passing through them in order. A
// new beat is taken every cycle as long as in_ready is high.
// Each stage holds its own valid bit and moves when the stage after it is
// empty or moving, so bubbles close up. When the receiver stalls, the output
// beat is held and the pipeline keeps filling; in_ready drops only once all
// 21 stages hold a beat. Reset empties every stage; no key or data state is
// kept between beats.
// ----------------------------------------------------------------------------
module aes128_block_cipher_unit
  import aes_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int NUM_STG = 2 * NUM_ROUNDS + 1;

  logic vld   [NUM_STG+1];
  logic rdy   [NUM_STG+1];
  stg_t dat   [NUM_STG+1];
  stg_t rnd_in;
  logic [NUM_STG-1:0] occ;

  assign vld[0]        = in_valid;
  assign in_ready      = rdy[0];
  assign dat[0].action = in_data.action;
  assign dat[0].key    = {in_data.key_hi, in_data.key_lo};
  assign dat[0].rk     = {in_data.key_hi, in_data.key_lo};
  assign dat[0].blk    = {in_data.block_hi, in_data.block_lo};

  genvar g;
  generate
    for (g = 0; g < NUM_ROUNDS; g++) begin : g_key
      aes_key_stage #(.STEP(g)) u_key (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vld[g]),
        .in_ready (rdy[g]),
        .in_data  (dat[g]),
        .out_valid(vld[g+1]),
        .out_ready(rdy[g+1]),
        .out_data (dat[g+1])
      );
    end
  endgenerate

  // decrypt starts from the last round key, encrypt from the cipher key
  always_comb begin
    rnd_in = dat[NUM_ROUNDS];
    if (dat[NUM_ROUNDS].action == ACT_ENCRYPT) begin
      rnd_in.rk = dat[NUM_ROUNDS].key;
    end
  end

  generate
    for (g = 0; g <= NUM_ROUNDS; g++) begin : g_rnd
      aes_round_stage #(.ROUND(g)) u_rnd (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vld[NUM_ROUNDS+g]),
        .in_ready (rdy[NUM_ROUNDS+g]),
        .in_data  ((g == 0) ? rnd_in : dat[NUM_ROUNDS+g]),
        .out_valid(vld[NUM_ROUNDS+g+1]),
        .out_ready(rdy[NUM_ROUNDS+g+1]),
        .out_data (dat[NUM_ROUNDS+g+1])
      );
    end
    for (g = 0; g < NUM_STG; g++) begin : g_occ
      assign occ[g] = vld[g+1];
    end
  endgenerate

  assign rdy[NUM_STG]       = out_ready;
  assign out_valid          = vld[NUM_STG];
  assign out_data.result_hi = dat[NUM_STG].blk[127:64];
  assign out_data.result_lo = dat[NUM_STG].blk[63:0];

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&occ) && !out_ready)
    else $error("input stalled with room in the pipeline");

  a_fill_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_ready) |=> occ[0])
    else $error("accepted beat missing from first stage");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

endmodule
